// ===== hw/rtl/bpcr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpcr_pkg
// Shared types and codes for the buffer pool clock replacer.
// ----------------------------------------------------------------------------
package bpcr_pkg;

   localparam int OP_W    = 2;
   localparam int PAGE_W  = 32;
   localparam int KIND_W  = 3;
   localparam int FRAME_W = 4;
   localparam int ACT_W   = 5;
   localparam int TRY_W   = 6;
   localparam int LIMIT   = 16;
   localparam logic [ACT_W-1:0] ACT_RESET = 5'd16;

   typedef enum logic [OP_W-1:0] {
      OP_FETCH = 2'd0,
      OP_UNPIN = 2'd1,
      OP_FLUSH = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_HIT        = 3'd0,
      KIND_WRITEBACK  = 3'd1,
      KIND_LOAD       = 3'd2,
      KIND_FULL       = 3'd3,
      KIND_UNPIN_DONE = 3'd4,
      KIND_UNPIN_MISS = 3'd5,
      KIND_FLUSH_DONE = 3'd6
   } kind_type;

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_LOOK  = 8'b0000_0010,
      S_SWEEP = 8'b0000_0100,
      S_WB    = 8'b0000_1000,
      S_LOAD  = 8'b0001_0000,
      S_FLUSH = 8'b0010_0000,
      S_FDONE = 8'b0100_0000,
      S_FULL  = 8'b1000_0000
   } state_type;

endpackage

// ===== hw/rtl/buffer_pool_clock_replacer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buffer_pool_clock_replacer_unit
// Frame table with clock second-chance victim selection.
// ----------------------------------------------------------------------------
// One request is worked at a time; req_stall is high from acceptance until
// the final word is placed in the output register. A single tag comparator
// and a single frame-state port visit one frame per cycle while the output
// side does not stall. A fetch hit or an unpin stops its lookup scan at the
// matching frame; a fetch miss scans all active frames, makes at most two turns
// of the clock sweep, then emits its writeback and load words; a flush visits
// every active frame. Each emitted word waits while the output side stalls.
// ----------------------------------------------------------------------------
module buffer_pool_clock_replacer_unit #(
   parameter int FRAMES   = 16,
   parameter int PIN_BITS = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [bpcr_pkg::OP_W-1:0]     req_op,
   input  logic [bpcr_pkg::PAGE_W-1:0]   req_page_id,
   input  logic                          req_dirty,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [bpcr_pkg::KIND_W-1:0]   rsp_kind,
   output logic [bpcr_pkg::FRAME_W-1:0]  rsp_frame,
   output logic [bpcr_pkg::PAGE_W-1:0]   rsp_page,
   output logic                          rsp_last,
   input  logic                          csr_we,
   input  logic [bpcr_pkg::ACT_W-1:0]    csr_wdata
);
   import bpcr_pkg::*;

   localparam int USED   = (FRAMES < LIMIT) ? FRAMES : LIMIT;
   localparam int FIDX_W = $clog2(USED);
   localparam logic [PIN_BITS-1:0] PIN_MAX = {PIN_BITS{1'b1}};

   state_type                 state_ff, state_in;
   logic [USED-1:0]           valid_ff, valid_in;
   logic [USED-1:0]           dirty_ff, dirty_in;
   logic [USED-1:0]           ref_ff, ref_in;
   logic [PIN_BITS-1:0]       pin_ff [USED];
   logic [PIN_BITS-1:0]       pin_in [USED];
   logic [PAGE_W-1:0]         tag_ff [USED];
   logic [FIDX_W-1:0]         hand_ff, hand_in;
   logic [FIDX_W-1:0]         idx_ff, idx_in;
   logic [FIDX_W-1:0]         vic_ff, vic_in;
   logic [TRY_W-1:0]          try_ff, try_in;
   logic [ACT_W-1:0]          act_ff, act_in;
   op_type                    op_ff, op_in;
   logic [PAGE_W-1:0]         pid_ff, pid_in;
   logic                      mark_ff, mark_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]         rsp_kind_ff, rsp_kind_in;
   logic [FRAME_W-1:0]        rsp_frame_ff, rsp_frame_in;
   logic [PAGE_W-1:0]         rsp_page_ff, rsp_page_in;
   logic                      rsp_last_ff, rsp_last_in;

   logic [ACT_W-1:0]          n_act;
   logic                      slot_free;
   logic                      match;
   logic                      idx_last;
   logic [ACT_W-1:0]          hand_p1;
   logic                      tag_we;

   always_comb begin
      priority if (act_ff == '0) begin
         n_act = ACT_W'(1);
      end else if (act_ff > ACT_W'(USED)) begin
         n_act = ACT_W'(USED);
      end else begin
         n_act = act_ff;
      end
   end

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign match     = valid_ff[idx_ff] && (tag_ff[idx_ff] == pid_ff);
   assign idx_last  = (ACT_W'(idx_ff) == (n_act - ACT_W'(1)));
   assign hand_p1   = ACT_W'(hand_ff) + ACT_W'(1);
   assign act_in    = csr_we ? csr_wdata : act_ff;

   always_comb begin
      state_in     = state_ff;
      valid_in     = valid_ff;
      dirty_in     = dirty_ff;
      ref_in       = ref_ff;
      pin_in       = pin_ff;
      hand_in      = hand_ff;
      idx_in       = idx_ff;
      vic_in       = vic_ff;
      try_in       = try_ff;
      op_in        = op_ff;
      pid_in       = pid_ff;
      mark_in      = mark_ff;
      tag_we       = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_kind_in  = rsp_kind_ff;
      rsp_frame_in = rsp_frame_ff;
      rsp_page_in  = rsp_page_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in   = op_type'(req_op);
               pid_in  = req_page_id;
               mark_in = req_dirty;
               idx_in  = '0;
               unique case (op_type'(req_op))
                  OP_FETCH, OP_UNPIN: state_in = S_LOOK;
                  OP_FLUSH:           state_in = S_FLUSH;
                  default:            state_in = S_IDLE;
               endcase
            end
         end
         S_LOOK: begin
            if (match) begin
               if (slot_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_frame_in = FRAME_W'(idx_ff);
                  rsp_page_in  = pid_ff;
                  rsp_last_in  = 1'b1;
                  if (op_ff == OP_FETCH) begin
                     rsp_kind_in = KIND_HIT;
                     ref_in[idx_ff] = 1'b1;
                     if (pin_ff[idx_ff] != PIN_MAX) begin
                        pin_in[idx_ff] = pin_ff[idx_ff] + PIN_BITS'(1);
                     end
                  end else begin
                     rsp_kind_in = KIND_UNPIN_DONE;
                     if (mark_ff) begin
                        dirty_in[idx_ff] = 1'b1;
                     end
                     if (pin_ff[idx_ff] != '0) begin
                        pin_in[idx_ff] = pin_ff[idx_ff] - PIN_BITS'(1);
                     end
                  end
                  state_in = S_IDLE;
               end
            end else if (idx_last) begin
               if (op_ff == OP_FETCH) begin
                  try_in   = '0;
                  state_in = S_SWEEP;
                  if (ACT_W'(hand_ff) >= n_act) begin
                     hand_in = '0;
                  end
               end else if (slot_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = KIND_UNPIN_MISS;
                  rsp_frame_in = '0;
                  rsp_page_in  = pid_ff;
                  rsp_last_in  = 1'b1;
                  state_in     = S_IDLE;
               end
            end else begin
               idx_in = idx_ff + FIDX_W'(1);
            end
         end
         S_SWEEP: begin
            if (try_ff == {n_act, 1'b0}) begin
               state_in = S_FULL;
            end else begin
               try_in  = try_ff + TRY_W'(1);
               hand_in = (hand_p1 >= n_act) ? '0 : FIDX_W'(hand_p1);
               vic_in  = hand_ff;
               if (!valid_ff[hand_ff]) begin
                  state_in = S_LOAD;
               end else if (pin_ff[hand_ff] == '0) begin
                  if (ref_ff[hand_ff]) begin
                     ref_in[hand_ff] = 1'b0;
                  end else begin
                     state_in = dirty_ff[hand_ff] ? S_WB : S_LOAD;
                  end
               end
            end
         end
         S_FULL: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_FULL;
               rsp_frame_in = '0;
               rsp_page_in  = pid_ff;
               rsp_last_in  = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_WB: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_WRITEBACK;
               rsp_frame_in = FRAME_W'(vic_ff);
               rsp_page_in  = tag_ff[vic_ff];
               rsp_last_in  = 1'b0;
               state_in     = S_LOAD;
            end
         end
         S_LOAD: begin
            if (slot_free) begin
               tag_we         = 1'b1;
               valid_in[vic_ff] = 1'b1;
               dirty_in[vic_ff] = 1'b0;
               ref_in[vic_ff]   = 1'b1;
               pin_in[vic_ff]   = PIN_BITS'(1);
               rsp_valid_in   = 1'b1;
               rsp_kind_in    = KIND_LOAD;
               rsp_frame_in   = FRAME_W'(vic_ff);
               rsp_page_in    = pid_ff;
               rsp_last_in    = 1'b1;
               state_in       = S_IDLE;
            end
         end
         S_FLUSH: begin
            if (!(valid_ff[idx_ff] && dirty_ff[idx_ff] && !slot_free)) begin
               if (valid_ff[idx_ff] && dirty_ff[idx_ff]) begin
                  dirty_in[idx_ff] = 1'b0;
                  rsp_valid_in     = 1'b1;
                  rsp_kind_in      = KIND_WRITEBACK;
                  rsp_frame_in     = FRAME_W'(idx_ff);
                  rsp_page_in      = tag_ff[idx_ff];
                  rsp_last_in      = 1'b0;
               end
               if (idx_last) begin
                  state_in = S_FDONE;
               end else begin
                  idx_in = idx_ff + FIDX_W'(1);
               end
            end
         end
         S_FDONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_FLUSH_DONE;
               rsp_frame_in = '0;
               rsp_page_in  = pid_ff;
               rsp_last_in  = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         dirty_ff     <= '0;
         ref_ff       <= '0;
         hand_ff      <= '0;
         act_ff       <= ACT_RESET;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < USED; i++) begin
            pin_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         dirty_ff     <= dirty_in;
         ref_ff       <= ref_in;
         hand_ff      <= hand_in;
         act_ff       <= act_in;
         rsp_valid_ff <= rsp_valid_in;
         pin_ff       <= pin_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      vic_ff       <= vic_in;
      try_ff       <= try_in;
      op_ff        <= op_in;
      pid_ff       <= pid_in;
      mark_ff      <= mark_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_frame_ff <= rsp_frame_in;
      rsp_page_ff  <= rsp_page_in;
      rsp_last_ff  <= rsp_last_in;
      if (tag_we) begin
         tag_ff[vic_ff] <= pid_ff;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_kind  = rsp_kind_ff;
   assign rsp_frame = rsp_frame_ff;
   assign rsp_page  = rsp_page_ff;
   assign rsp_last  = rsp_last_ff;

endmodule

// ===== hw/rtl/bpcr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpcr_checker
// Port-level checks for the buffer pool clock replacer, bound to the top.
// ----------------------------------------------------------------------------
module bpcr_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic [bpcr_pkg::OP_W-1:0]     req_op,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [bpcr_pkg::KIND_W-1:0]   rsp_kind,
   input logic [bpcr_pkg::FRAME_W-1:0]  rsp_frame,
   input logic [bpcr_pkg::PAGE_W-1:0]   rsp_page,
   input logic                          rsp_last
);
   import bpcr_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_frame)
                                 && $stable(rsp_page) && $stable(rsp_last))
      else $error("output word changed while stalled");

   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == (rsp_kind != KIND_WRITEBACK)))
      else $error("last flag does not match word kind");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_op != OP_NONE) |=> req_stall)
      else $error("request not held busy after acceptance");

   a_frame_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_FULL || rsp_kind == KIND_UNPIN_MISS
                    || rsp_kind == KIND_FLUSH_DONE) |-> (rsp_frame == '0))
      else $error("frame field not zero on a frameless word");

endmodule

bind buffer_pool_clock_replacer_unit bpcr_checker u_bpcr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_op    (req_op),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_kind  (rsp_kind),
   .rsp_frame (rsp_frame),
   .rsp_page  (rsp_page),
   .rsp_last  (rsp_last)
);
